[rtl/nec_ir_frame_decoder_assert.svh]
// Assertion macros for the infrared frame decoder RTL.
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// Immediate-cycle property, checked on every rising clock edge outside reset.
`define NEC_IR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication into the next cycle, checked outside reset.
`define NEC_IR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[rtl/nec_ir_pkg.sv]
// Types and constants for the infrared frame decoder.
package nec_ir_pkg;

  localparam int unsigned TickW      = 15;
  localparam int unsigned CountW     = 6;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CfgIndexW  = 3;

  localparam logic [CountW-1:0] FrameSymbols = 6'd33;
  localparam int unsigned CmdLsb = 16;
  localparam int unsigned InvLsb = 24;
  localparam logic [7:0] ByteMask = 8'hFF;

  localparam logic [TickW-1:0] LeaderPulseMinReset = 15'd8000;
  localparam logic [TickW-1:0] LeaderPulseMaxReset = 15'd10000;
  localparam logic [TickW-1:0] LeaderSpaceMinReset = 15'd4000;
  localparam logic [TickW-1:0] LeaderSpaceMaxReset = 15'd5000;
  localparam logic [TickW-1:0] OneSpaceThreshReset = 15'd1000;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_LEADER_PULSE_MIN = 3'd0,
    CFG_LEADER_PULSE_MAX = 3'd1,
    CFG_LEADER_SPACE_MIN = 3'd2,
    CFG_LEADER_SPACE_MAX = 3'd3,
    CFG_ONE_SPACE_THRESH = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LEADER   = 3'd2,
    ST_ZERO     = 3'd3,
    ST_MISMATCH = 3'd4
  } status_t;

  typedef struct packed {
    logic [TickW-1:0] leader_pulse_min;
    logic [TickW-1:0] leader_pulse_max;
    logic [TickW-1:0] leader_space_min;
    logic [TickW-1:0] leader_space_max;
    logic [TickW-1:0] one_space_threshold;
  } cfg_t;

endpackage

[rtl/nec_ir_cfg.sv]
// Configuration register file for the infrared frame decoder.
module nec_ir_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [nec_ir_pkg::CfgIndexW-1:0]  wr_index,
  input  logic [nec_ir_pkg::TickW-1:0]      wr_data,
  output nec_ir_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_pulse_min    <= nec_ir_pkg::LeaderPulseMinReset;
      cfg.leader_pulse_max    <= nec_ir_pkg::LeaderPulseMaxReset;
      cfg.leader_space_min    <= nec_ir_pkg::LeaderSpaceMinReset;
      cfg.leader_space_max    <= nec_ir_pkg::LeaderSpaceMaxReset;
      cfg.one_space_threshold <= nec_ir_pkg::OneSpaceThreshReset;
    end else if (wr_en) begin
      unique case (wr_index)
        nec_ir_pkg::CFG_LEADER_PULSE_MIN: cfg.leader_pulse_min    <= wr_data;
        nec_ir_pkg::CFG_LEADER_PULSE_MAX: cfg.leader_pulse_max    <= wr_data;
        nec_ir_pkg::CFG_LEADER_SPACE_MIN: cfg.leader_space_min    <= wr_data;
        nec_ir_pkg::CFG_LEADER_SPACE_MAX: cfg.leader_space_max    <= wr_data;
        nec_ir_pkg::CFG_ONE_SPACE_THRESH: cfg.one_space_threshold <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/nec_ir_frame_decoder.sv]
// Infrared frame decoder: one mark/space symbol per cycle unless stalled, one result
// per frame. Symbols are taken one per clock cycle while s_axis_tready is high: each
// symbol updates the frame state (symbol count, leader check, data bits) in the same
// cycle it is accepted, and the symbol flagged tlast loads the result register, which
// shows the result in the next cycle. s_axis_tready drops only while a finished result
// sits in the result register and m_axis_tready is low; a result taken in the
// same cycle frees the register for the next frame end. The first symbol is the
// leader, symbols 1 to 32 carry data bits LSB first, later symbols are ignored.
// Configuration writes are always ready and apply from the next symbol on.
`include "nec_ir_frame_decoder_assert.svh"

module nec_ir_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [14:0] pulse_ticks, [29:15] space_ticks, zero fill
  input  logic        s_axis_tlast,   // frame_end
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] status, [10:3] command, zero fill
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nec_ir_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [nec_ir_pkg::TickW-1:0]     cfg_data
);

  nec_ir_pkg::cfg_t cfg;

  logic [nec_ir_pkg::TickW-1:0]  pulse_ticks;
  logic [nec_ir_pkg::TickW-1:0]  space_ticks;
  logic                          in_acc;

  logic [nec_ir_pkg::CountW-1:0] symbol_count;
  logic [nec_ir_pkg::CountW-1:0] symbol_count_next;
  logic                          leader_good;
  logic                          leader_good_next;
  logic [nec_ir_pkg::DataW-1:0]  data_shift;
  logic [nec_ir_pkg::DataW-1:0]  data_shift_next;
  logic [nec_ir_pkg::CountW-1:0] bit_pos;

  logic [7:0]                    cmd_byte;
  logic [7:0]                    inv_byte;
  nec_ir_pkg::status_t           status_next;
  logic [7:0]                    command_next;

  assign cfg_ready = 1'b1;

  nec_ir_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign pulse_ticks   = s_axis_tdata[14:0];
  assign space_ticks   = s_axis_tdata[29:15];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign bit_pos       = symbol_count - 6'd1;

  always_comb begin
    leader_good_next  = leader_good;
    data_shift_next   = data_shift;
    symbol_count_next = symbol_count;
    if (symbol_count == '0) begin
      leader_good_next = (pulse_ticks >= cfg.leader_pulse_min) &&
                         (pulse_ticks <= cfg.leader_pulse_max) &&
                         (space_ticks >= cfg.leader_space_min) &&
                         (space_ticks <= cfg.leader_space_max);
    end else if (symbol_count < nec_ir_pkg::FrameSymbols) begin
      if (space_ticks > cfg.one_space_threshold) begin
        data_shift_next[bit_pos[4:0]] = 1'b1;
      end
    end
    if (symbol_count < nec_ir_pkg::FrameSymbols) begin
      symbol_count_next = symbol_count + 6'd1;
    end
  end

  assign cmd_byte = data_shift_next[nec_ir_pkg::CmdLsb +: 8];
  assign inv_byte = data_shift_next[nec_ir_pkg::InvLsb +: 8];

  always_comb begin
    priority if (symbol_count_next < nec_ir_pkg::FrameSymbols) begin
      status_next = nec_ir_pkg::ST_SHORT;
    end else if (!leader_good_next) begin
      status_next = nec_ir_pkg::ST_LEADER;
    end else if (data_shift_next == '0) begin
      status_next = nec_ir_pkg::ST_ZERO;
    end else if ((cmd_byte ^ inv_byte) != nec_ir_pkg::ByteMask) begin
      status_next = nec_ir_pkg::ST_MISMATCH;
    end else begin
      status_next = nec_ir_pkg::ST_OK;
    end
    command_next = (status_next == nec_ir_pkg::ST_OK) ? cmd_byte : 8'd0;
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      leader_good  <= 1'b0;
      data_shift   <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        symbol_count <= '0;
        leader_good  <= 1'b0;
        data_shift   <= '0;
      end else begin
        symbol_count <= symbol_count_next;
        leader_good  <= leader_good_next;
        data_shift   <= data_shift_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_acc && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tlast) begin
      m_axis_tdata <= {5'd0, command_next, status_next};
    end
  end

  `NEC_IR_ASSERT(a_count_saturates, symbol_count <= nec_ir_pkg::FrameSymbols,
    "symbol count ran past the frame length")
  `NEC_IR_ASSERT_NEXT(a_end_gives_result, in_acc && s_axis_tlast, m_axis_tvalid,
    "frame end produced no result")
  `NEC_IR_ASSERT_NEXT(a_end_clears_frame, in_acc && s_axis_tlast,
    symbol_count == '0 && !leader_good && data_shift == '0,
    "frame state not cleared after frame end")
  `NEC_IR_ASSERT(a_cmd_zero_unless_ok,
    !m_axis_tvalid || m_axis_tdata[2:0] == nec_ir_pkg::ST_OK || m_axis_tdata[10:3] == 8'd0,
    "command nonzero on a failed frame")

endmodule

[sim/nec_ir_frame_decoder_checker.sv]
// Predicts frame results from observed symbols and register writes and compares them.
module nec_ir_frame_decoder_checker
  import nec_ir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [15:0]          m_axis_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [TickW-1:0]     cfg_data,
  output int unsigned          result_errors,
  output int unsigned          results_outstanding
);

  typedef struct packed {
    status_t    status;
    logic [7:0] command;
  } frame_result_t;

  frame_result_t      expected_results[$];
  cfg_t               regs;
  logic [CountW-1:0]  sym_count;
  logic               leader_ok;
  logic [DataW-1:0]   frame_bits;
  int unsigned        errors;

  initial begin
    result_errors = 0;
    results_outstanding = 0;
  end

  always @(posedge clk) begin : predict_and_compare
    logic [TickW-1:0] pulse;
    logic [TickW-1:0] space;
    logic [7:0]       cmd;
    logic [7:0]       inv;
    frame_result_t    want;
    frame_result_t    got;
    if (rst) begin
      regs.leader_pulse_min    = LeaderPulseMinReset;
      regs.leader_pulse_max    = LeaderPulseMaxReset;
      regs.leader_space_min    = LeaderSpaceMinReset;
      regs.leader_space_max    = LeaderSpaceMaxReset;
      regs.one_space_threshold = OneSpaceThreshReset;
      sym_count  = '0;
      leader_ok  = 1'b0;
      frame_bits = '0;
      errors     = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = status_t'(m_axis_tdata[2:0]);
        got.command = m_axis_tdata[10:3];
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status=%0d command=%02h", got.status, got.command);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.command !== want.command) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: expected status=%0d command=%02h, got status=%0d command=%02h",
                       want.status, want.command, got.status, got.command);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        pulse = s_axis_tdata[TickW-1:0];
        space = s_axis_tdata[2*TickW-1:TickW];
        if (sym_count == 0) begin
          leader_ok = pulse >= regs.leader_pulse_min && pulse <= regs.leader_pulse_max &&
                      space >= regs.leader_space_min && space <= regs.leader_space_max;
        end else if (sym_count < FrameSymbols) begin
          if (space > regs.one_space_threshold)
            frame_bits[sym_count - 1'b1] = 1'b1;
        end
        if (sym_count < FrameSymbols)
          sym_count = sym_count + 1'b1;

        if (s_axis_tlast) begin
          cmd = frame_bits[CmdLsb +: 8];
          inv = frame_bits[InvLsb +: 8];
          if (sym_count < FrameSymbols)
            want.status = ST_SHORT;
          else if (!leader_ok)
            want.status = ST_LEADER;
          else if (frame_bits == '0)
            want.status = ST_ZERO;
          else if ((cmd ^ inv) != ByteMask)
            want.status = ST_MISMATCH;
          else
            want.status = ST_OK;
          want.command = (want.status == ST_OK) ? cmd : 8'h00;
          expected_results.push_back(want);
          sym_count  = '0;
          leader_ok  = 1'b0;
          frame_bits = '0;
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_LEADER_PULSE_MIN: regs.leader_pulse_min    = cfg_data;
          CFG_LEADER_PULSE_MAX: regs.leader_pulse_max    = cfg_data;
          CFG_LEADER_SPACE_MIN: regs.leader_space_min    = cfg_data;
          CFG_LEADER_SPACE_MAX: regs.leader_space_max    = cfg_data;
          CFG_ONE_SPACE_THRESH: regs.one_space_threshold = cfg_data;
          default: ;
        endcase
      end
    end
    result_errors       <= errors;
    results_outstanding <= expected_results.size();
  end

endmodule

[sim/nec_ir_frame_decoder_tb.sv]
// Testbench top: drives symbol frames and register writes into the infrared decoder.
module nec_ir_frame_decoder_tb;
  import nec_ir_pkg::*;

  localparam logic [CfgIndexW-1:0] CfgIndexSpareLo = 3'd5;
  localparam logic [CfgIndexW-1:0] CfgIndexTop     = {CfgIndexW{1'b1}};
  localparam logic [TickW-1:0]     TickMax         = {TickW{1'b1}};
  localparam int                   HoldCycles      = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [TickW-1:0]     cfg_data = '0;

  int unsigned result_errors;
  int unsigned results_outstanding;

  int   tx_idle_pct = 29;
  int   rx_idle_pct = 73;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   symbols_sent = 0;
  cfg_t cur;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nec_ir_frame_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  nec_ir_frame_decoder_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .s_axis_tvalid       (s_axis_tvalid),
    .s_axis_tready       (s_axis_tready),
    .s_axis_tdata        (s_axis_tdata),
    .s_axis_tlast        (s_axis_tlast),
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tready       (m_axis_tready),
    .m_axis_tdata        (m_axis_tdata),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .result_errors       (result_errors),
    .results_outstanding (results_outstanding)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  function automatic logic [TickW-1:0] pick_in(input logic [TickW-1:0] lo, hi);
    if (lo <= hi)
      return TickW'($urandom_range(hi, lo));
    return TickW'($urandom);
  endfunction

  function automatic logic [TickW-1:0] space_for_bit(input logic one);
    if (!one)
      return TickW'($urandom_range(cur.one_space_threshold, 0));
    if (cur.one_space_threshold == TickMax)
      return TickMax;
    return TickW'($urandom_range(TickMax, int'(cur.one_space_threshold) + 1));
  endfunction

  task automatic send_symbol(input logic [TickW-1:0] pulse, space, input logic last);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, space, pulse};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    symbols_sent++;
  endtask

  task automatic send_frame(input int len, input logic [DataW-1:0] word, input bit leader_in_window);
    logic [TickW-1:0] pulse;
    logic [TickW-1:0] space;
    for (int i = 0; i < len; i++) begin
      pulse = TickW'($urandom);
      if (i == 0 && leader_in_window) begin
        pulse = pick_in(cur.leader_pulse_min, cur.leader_pulse_max);
        space = pick_in(cur.leader_space_min, cur.leader_space_max);
      end else if (i == 0 || i > 32) begin
        space = TickW'($urandom);
      end else begin
        space = space_for_bit(word[i-1]);
      end
      send_symbol(pulse, space, i == len - 1);
    end
  endtask

  task automatic wait_idle(input int tail);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0)
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] index, input logic [TickW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
  endtask

  task automatic set_config(input cfg_t c);
    wait_idle(4);
    write_reg(CFG_LEADER_PULSE_MIN, c.leader_pulse_min);
    write_reg(CFG_LEADER_PULSE_MAX, c.leader_pulse_max);
    write_reg(CFG_LEADER_SPACE_MIN, c.leader_space_min);
    write_reg(CFG_LEADER_SPACE_MAX, c.leader_space_max);
    write_reg(CFG_ONE_SPACE_THRESH, c.one_space_threshold);
    write_reg(CfgIndexW'($urandom_range(CfgIndexTop, CfgIndexSpareLo)), TickW'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur = c;
  endtask

  function automatic cfg_t random_windows();
    cfg_t c;
    c.leader_pulse_min    = TickW'($urandom_range(16000, 0));
    c.leader_pulse_max    = c.leader_pulse_min + TickW'($urandom_range(16000, 0));
    c.leader_space_min    = TickW'($urandom_range(16000, 0));
    c.leader_space_max    = c.leader_space_min + TickW'($urandom_range(16000, 0));
    c.one_space_threshold = TickW'($urandom_range(TickMax - 1, 0));
    return c;
  endfunction

  task automatic run_frames(input int target);
    int         start;
    int         kind;
    logic [7:0] cmd;
    start = symbols_sent;
    while (symbols_sent - start < target) begin
      kind = $urandom_range(99, 0);
      cmd  = 8'($urandom);
      if (kind < 45)
        send_frame(($urandom_range(4, 0) == 0) ? 33 + $urandom_range(3, 1) : 33,
                   {~cmd, cmd, 16'($urandom)}, 1'b1);
      else if (kind < 55)
        send_frame(33, {~cmd ^ 8'($urandom_range(255, 1)), cmd, 16'($urandom)}, 1'b1);
      else if (kind < 62)
        send_frame(33, '0, 1'b1);
      else if (kind < 72)
        send_frame(33, {~cmd, cmd, 16'($urandom)}, 1'b0);
      else if (kind < 85)
        send_frame($urandom_range(32, 1), $urandom, 1'($urandom));
      else
        send_frame($urandom_range(36, 33), $urandom, 1'($urandom));
    end
  endtask

  initial begin
    #2000000;
    $display("FAIL nec_ir_frame_decoder");
    $finish;
  end

  initial begin
    cfg_t c;
    cur.leader_pulse_min    = LeaderPulseMinReset;
    cur.leader_pulse_max    = LeaderPulseMaxReset;
    cur.leader_space_min    = LeaderSpaceMinReset;
    cur.leader_space_max    = LeaderSpaceMaxReset;
    cur.one_space_threshold = OneSpaceThreshReset;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_symbol('0, '0, 1'b1);
    send_symbol(TickMax, TickMax, 1'b1);
    send_symbol(TickMax, '0, 1'b0);
    send_symbol('0, TickMax, 1'b1);
    send_symbol(LeaderPulseMinReset, LeaderSpaceMaxReset, 1'b0);
    send_symbol('0, OneSpaceThreshReset, 1'b0);
    send_symbol(TickMax, OneSpaceThreshReset + 1'b1, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 73 : 0;
      rx_idle_pct = (mode == 0) ? 73 : (mode == 1) ? 29 : 0;
      for (int step = 0; step < 2; step++) begin
        case (mode * 2 + step)
          0: c = cur;
          1: c = random_windows();
          2: c = '0;
          3: c = '1;
          4: begin
            c = random_windows();
            c.leader_pulse_min = TickMax;
            c.leader_pulse_max = '0;
            c.leader_space_min = TickMax;
            c.leader_space_max = '0;
          end
          default: c = random_windows();
        endcase
        set_config(c);
        if (mode == 2 && step == 1) begin
          hold_seq <= hold_seq + 1;
          for (int n = 0; n < 40; n++)
            send_frame($urandom_range(3, 1), $urandom, 1'($urandom));
        end
        run_frames(100);
      end
    end

    wait_idle(16);
    if (result_errors == 0)
      $display("PASS nec_ir_frame_decoder");
    else
      $display("FAIL nec_ir_frame_decoder");
    $finish;
  end

endmodule
